@@ rtl/dnsarp_pkg.sv @@
package dnsarp_pkg;

  // Parse phases of the message walker.
  typedef enum logic [3:0] {
    PH_HEADER   = 4'd0,
    PH_QNAME    = 4'd1,
    PH_QPTR     = 4'd2,
    PH_QFIXED   = 4'd3,
    PH_ANAME    = 4'd4,
    PH_APTR     = 4'd5,
    PH_AFIXED   = 4'd6,
    PH_ASKIP    = 4'd7,
    PH_DONE     = 4'd8,
    PH_BADID    = 4'd9,
    PH_NOANS    = 4'd10,
    PH_ACAPTURE = 4'd11
  } phase_t;

  // Status codes carried with each result item.
  typedef enum logic [2:0] {
    ST_RESOLVED = 3'd0,
    ST_SHORT    = 3'd1,
    ST_BADID    = 3'd2,
    ST_NOANS    = 3'd3,
    ST_NOMATCH  = 3'd4
  } status_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_QUERY_ID     = 2'd0;
  localparam logic [1:0] CFG_RECORD_TYPE  = 2'd1;
  localparam logic [1:0] CFG_RECORD_CLASS = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [15:0] RESET_QUERY_ID     = 16'hCAFE;
  localparam logic [15:0] RESET_RECORD_TYPE  = 16'd1;
  localparam logic [15:0] RESET_RECORD_CLASS = 16'd1;

  // Fixed protocol constants.
  localparam logic [3:0]  HEADER_BYTES    = 4'd12;
  localparam logic [3:0]  QFIXED_BYTES    = 4'd4;
  localparam logic [3:0]  AFIXED_BYTES    = 4'd10;
  localparam logic [3:0]  ADDRESS_BYTES   = 4'd4;
  localparam logic [15:0] ADDRESS_LENGTH  = 16'd4;
  localparam logic [1:0]  POINTER_MARK    = 2'b11;

  typedef struct packed {
    logic [15:0] expected_query_id;
    logic [15:0] wanted_record_type;
    logic [15:0] wanted_record_class;
  } cfg_t;

  typedef struct packed {
    logic [31:0] address;
    status_t     status;
  } result_t;

endpackage

@@ rtl/dnsarp_parser.sv @@
module dnsarp_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               byte_fire,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  input  dnsarp_pkg::cfg_t    cfg,
  output logic               res_valid,
  output dnsarp_pkg::result_t res
);
  import dnsarp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  hpos_r, hpos_nxt;
  logic [15:0] id_r, id_nxt;
  logic [15:0] qleft_r, qleft_nxt;
  logic [15:0] aleft_r, aleft_nxt;
  logic [7:0]  label_r, label_nxt;
  logic [3:0]  field_r, field_nxt;
  logic [15:0] rtype_r, rtype_nxt;
  logic [15:0] rclass_r, rclass_nxt;
  logic [15:0] dlen_r, dlen_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic        match_r, match_nxt;

  logic        name_busy, name_end, name_ptr;
  logic [3:0]  hpos_inc, field_inc;
  logic        hdr_done, afix_done;
  logic [15:0] qleft_dec, aleft_dec, dlen_dec, dlen_new;
  logic        record_match;

  // Shared decode of the byte against the current counters.
  assign name_busy    = (label_r != 8'd0);
  assign name_end     = !name_busy && (data_byte == 8'd0);
  assign name_ptr     = !name_busy && (data_byte[7:6] == POINTER_MARK);
  assign hpos_inc     = hpos_r + 4'd1;
  assign field_inc    = field_r + 4'd1;
  assign hdr_done     = (hpos_inc >= HEADER_BYTES);
  assign afix_done    = (field_inc >= AFIXED_BYTES);
  assign qleft_dec    = qleft_r - 16'd1;
  assign aleft_dec    = aleft_r - 16'd1;
  assign dlen_dec     = dlen_r - 16'd1;
  assign dlen_new     = (field_r >= 4'd8) ? {dlen_r[7:0], data_byte} : dlen_r;
  assign record_match = (rtype_r == cfg.wanted_record_type) &&
                        (rclass_r == cfg.wanted_record_class) &&
                        (dlen_new == ADDRESS_LENGTH);

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_HEADER: begin
        if (hdr_done) begin
          if (id_r != cfg.expected_query_id) phase_nxt = PH_BADID;
          else if (aleft_r == 16'd0)         phase_nxt = PH_NOANS;
          else if (qleft_r != 16'd0)         phase_nxt = PH_QNAME;
          else                               phase_nxt = PH_ANAME;
        end
      end
      PH_QNAME: begin
        if (name_end)      phase_nxt = PH_QFIXED;
        else if (name_ptr) phase_nxt = PH_QPTR;
      end
      PH_QPTR: phase_nxt = PH_QFIXED;
      PH_QFIXED: begin
        if (field_inc >= QFIXED_BYTES) begin
          phase_nxt = (qleft_dec != 16'd0) ? PH_QNAME : PH_ANAME;
        end
      end
      PH_ANAME: begin
        if (name_end)      phase_nxt = PH_AFIXED;
        else if (name_ptr) phase_nxt = PH_APTR;
      end
      PH_APTR: phase_nxt = PH_AFIXED;
      PH_AFIXED: begin
        if (afix_done) begin
          if (record_match)            phase_nxt = PH_ACAPTURE;
          else if (dlen_new == 16'd0)  phase_nxt = (aleft_dec != 16'd0) ? PH_ANAME : PH_DONE;
          else                         phase_nxt = PH_ASKIP;
        end
      end
      PH_ASKIP: begin
        if (dlen_dec == 16'd0) phase_nxt = (aleft_dec != 16'd0) ? PH_ANAME : PH_DONE;
      end
      PH_ACAPTURE: begin
        if (field_inc >= ADDRESS_BYTES) phase_nxt = PH_DONE;
      end
      default: phase_nxt = phase_r;
    endcase
  end

  // Counters and captured fields.
  always_comb begin
    hpos_nxt   = hpos_r;
    id_nxt     = id_r;
    qleft_nxt  = qleft_r;
    aleft_nxt  = aleft_r;
    label_nxt  = label_r;
    field_nxt  = field_r;
    rtype_nxt  = rtype_r;
    rclass_nxt = rclass_r;
    dlen_nxt   = dlen_r;
    addr_nxt   = addr_r;
    match_nxt  = match_r;
    case (phase_r)
      PH_HEADER: begin
        if (hpos_r <= 4'd1)                       id_nxt    = {id_r[7:0], data_byte};
        else if (hpos_r == 4'd4 || hpos_r == 4'd5) qleft_nxt = {qleft_r[7:0], data_byte};
        else if (hpos_r == 4'd6 || hpos_r == 4'd7) aleft_nxt = {aleft_r[7:0], data_byte};
        hpos_nxt = hpos_inc;
      end
      PH_QNAME, PH_ANAME: begin
        if (name_busy)      label_nxt = label_r - 8'd1;
        else if (name_end)  field_nxt = 4'd0;
        else if (!name_ptr) label_nxt = data_byte;
      end
      PH_QPTR, PH_APTR: field_nxt = 4'd0;
      PH_QFIXED: begin
        field_nxt = field_inc;
        if (field_inc >= QFIXED_BYTES) begin
          field_nxt = 4'd0;
          label_nxt = 8'd0;
          qleft_nxt = qleft_dec;
        end
      end
      PH_AFIXED: begin
        if (field_r <= 4'd1)      rtype_nxt  = {rtype_r[7:0], data_byte};
        else if (field_r <= 4'd3) rclass_nxt = {rclass_r[7:0], data_byte};
        dlen_nxt  = dlen_new;
        field_nxt = field_inc;
        if (afix_done) begin
          field_nxt = 4'd0;
          if (record_match) begin
            addr_nxt = 32'd0;
          end else if (dlen_new == 16'd0) begin
            aleft_nxt = aleft_dec;
            label_nxt = 8'd0;
          end
        end
      end
      PH_ASKIP: begin
        dlen_nxt = dlen_dec;
        if (dlen_dec == 16'd0) begin
          aleft_nxt = aleft_dec;
          label_nxt = 8'd0;
          field_nxt = 4'd0;
        end
      end
      PH_ACAPTURE: begin
        addr_nxt  = {addr_r[23:0], data_byte};
        field_nxt = field_inc;
        if (field_inc >= ADDRESS_BYTES) match_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  // Result on the last byte, judged on the state after this byte.
  always_comb begin
    res_valid   = byte_fire && last_byte;
    res.address = 32'd0;
    if (phase_nxt == PH_HEADER)     res.status = ST_SHORT;
    else if (phase_nxt == PH_BADID) res.status = ST_BADID;
    else if (phase_nxt == PH_NOANS) res.status = ST_NOANS;
    else if (match_nxt) begin
      res.status  = ST_RESOLVED;
      res.address = addr_nxt;
    end else begin
      res.status = ST_NOMATCH;
    end
  end

  // State registers; the last byte returns the walker to its start.
  always_ff @(posedge clk) begin
    if (!rst_n || (byte_fire && last_byte)) begin
      phase_r  <= PH_HEADER;
      hpos_r   <= 4'd0;
      id_r     <= 16'd0;
      qleft_r  <= 16'd0;
      aleft_r  <= 16'd0;
      label_r  <= 8'd0;
      field_r  <= 4'd0;
      rtype_r  <= 16'd0;
      rclass_r <= 16'd0;
      dlen_r   <= 16'd0;
      addr_r   <= 32'd0;
      match_r  <= 1'b0;
    end else if (byte_fire) begin
      phase_r  <= phase_nxt;
      hpos_r   <= hpos_nxt;
      id_r     <= id_nxt;
      qleft_r  <= qleft_nxt;
      aleft_r  <= aleft_nxt;
      label_r  <= label_nxt;
      field_r  <= field_nxt;
      rtype_r  <= rtype_nxt;
      rclass_r <= rclass_nxt;
      dlen_r   <= dlen_nxt;
      addr_r   <= addr_nxt;
      match_r  <= match_nxt;
    end
  end

endmodule

@@ rtl/dns_response_a_record_parser_top.sv @@
// Channel  Direction  Ports                                  Payload
// in_      input      in_tvalid/in_tready/in_tdata/in_tlast  message byte, last mark
// out_     output     out_tvalid/out_tready/out_tdata        status, address
// cfg_     input      cfg_valid/cfg_ready/cfg_index/cfg_data 16-bit register write
//
// One byte is taken every cycle while the skid entry is free; after its last byte a
// result passes the input register and then the output register.
// The rate is set by the parser updating its phase and counters once per byte.
// Reset is synchronous and active low; it restores the registers and the parser.
// An output register with a skid entry lets bytes keep flowing while a result
// waits; input stalls only when both hold undelivered results.
module dns_response_a_record_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [2:0] status, [34:3] address, [39:35] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import dnsarp_pkg::*;

  cfg_t    cfg_r;
  logic    in_valid_r;
  logic [7:0] in_byte_r;
  logic    in_last_r;
  logic    fire;
  logic    res_valid;
  result_t res;
  logic    out_valid_r, out_valid_nxt;
  result_t out_data_r, out_data_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t skid_data_r, skid_data_nxt;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_query_id   <= RESET_QUERY_ID;
      cfg_r.wanted_record_type  <= RESET_RECORD_TYPE;
      cfg_r.wanted_record_class <= RESET_RECORD_CLASS;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_QUERY_ID:     cfg_r.expected_query_id   <= cfg_data;
        CFG_RECORD_TYPE:  cfg_r.wanted_record_type  <= cfg_data;
        CFG_RECORD_CLASS: cfg_r.wanted_record_class <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register; the parser consumes it whenever the skid entry is free.
  assign fire      = in_valid_r && !skid_valid_r;
  assign in_tready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  dnsarp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_fire (fire),
    .data_byte (in_byte_r),
    .last_byte (in_last_r),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register and skid entry, kept in order.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = res_valid;
        out_data_nxt  = res;
      end
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_data_r.address, out_data_r.status};

  // The skid entry is only ever filled behind a waiting output item.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds an item while the output register is empty");

  // A stalled result is never dropped.
  a_out_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> out_valid_r)
    else $error("stalled result was lost");

  // Only a resolved result carries an address.
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status != ST_RESOLVED) |-> (out_data_r.address == 32'd0))
    else $error("unresolved result carries an address");

endmodule
